/* design/irlm_pkg.sv */
// Shared types and constants for the IPv4 range list matcher.
`timescale 1ns / 1ps
`default_nettype none
package irlm_pkg;

	localparam logic [7:0]  CH_DOT     = 8'h2e;
	localparam logic [7:0]  CH_SLASH   = 8'h2f;
	localparam logic [7:0]  CH_ZERO    = 8'h30;
	localparam logic [7:0]  CH_NINE    = 8'h39;
	localparam logic [7:0]  CH_END     = 8'h00;
	localparam logic [31:0] ALL_ONES   = 32'hffffffff;
	localparam logic [9:0]  OCTET_MAX  = 10'd255;
	localparam logic [9:0]  PREFIX_MAX = 10'd32;
	localparam logic [1:0]  LAST_OCTET = 2'd3;
	localparam logic [1:0]  MAX_DIGITS = 2'd3;

	typedef enum logic [1:0] {
		PH_GAP,
		PH_ADDR,
		PH_PREFIX,
		PH_MASK
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_word_t;

	typedef struct packed {
		logic match_found;
		logic syntax_error;
	} out_word_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  octet_index;
		logic [1:0]  digit_count;
		logic [9:0]  number_value;
		logic [31:0] network_value;
		logic [31:0] mask_value;
		logic        found;
		logic        error;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:         PH_GAP,
		octet_index:   2'd0,
		digit_count:   2'd0,
		number_value:  10'd0,
		network_value: 32'd0,
		mask_value:    ALL_ONES,
		found:         1'b0,
		error:         1'b0
	};

endpackage
`default_nettype wire

/* design/ipv4_range_list_matcher.sv */
// Top level: input register, parser core, result register and address register.
// A result word is registered in the result register when its last character word leaves the input register.
// Throughput: one character word per cycle; a last character waits in the input
// register only while the result register holds a word that is not taken.
// Reset clears the parser, the pipeline valids and the test address to zero.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_range_list_matcher (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire irlm_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output irlm_pkg::out_word_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [31:0]         cfg_data
);

	logic                valid_s1;
	irlm_pkg::in_word_t  word_s1;
	logic                fire_s1;
	logic                out_valid_q;
	irlm_pkg::out_word_t out_word_q;
	irlm_pkg::out_word_t core_result;
	logic [31:0]         test_address_q;

	assign fire_s1   = valid_s1 && (!word_s1.last_char || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	irlm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (fire_s1),
		.word         (word_s1),
		.test_address (test_address_q),
		.result       (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_address_q <= 32'd0;
		end else if (cfg_we) begin
			test_address_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && word_s1.last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && word_s1.last_char) begin
			out_word_q <= core_result;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(fire_s1 && word_s1.last_char))
		else $error("result word overwritten before it was taken");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && word_s1.last_char && out_valid_q)
		else $error("input stalled without a pending result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && word_s1.last_char |=> out_valid_q)
		else $error("result word missing after last character");

endmodule
`default_nettype wire

/* design/irlm_step.sv */
// Next parser state for one character of the list.
`timescale 1ns / 1ps
`default_nettype none
module irlm_step (
	input  wire irlm_pkg::parse_state_t state_in,
	input  wire logic [7:0]             char_code,
	input  wire logic [31:0]            test_address,
	output irlm_pkg::parse_state_t      state_out
);

	logic        is_digit;
	logic [9:0]  digit_value;
	logic [9:0]  acc_value;
	logic [1:0]  count_next;
	logic [31:0] network_next;
	logic [31:0] mask_next;
	logic [31:0] prefix_mask;
	logic [5:0]  prefix_shift;

	function automatic irlm_pkg::parse_state_t finish_entry(
		input irlm_pkg::parse_state_t s,
		input logic [31:0]            mask,
		input logic [31:0]            addr,
		input logic                   dig
	);
		irlm_pkg::parse_state_t r;
		r = s;
		r.mask_value = mask;
		if ((addr & mask) == (s.network_value & mask)) begin
			r.found = 1'b1;
		end else if (dig) begin
			r.error = 1'b1;
		end else begin
			r.phase = irlm_pkg::PH_GAP;
		end
		return r;
	endfunction

	assign is_digit     = (char_code >= irlm_pkg::CH_ZERO) && (char_code <= irlm_pkg::CH_NINE);
	assign digit_value  = {2'b00, char_code - irlm_pkg::CH_ZERO};
	assign acc_value    = 10'(state_in.number_value * 10'd10) + digit_value;
	assign count_next   = state_in.digit_count + 2'd1;
	assign network_next = {state_in.network_value[23:0], state_in.number_value[7:0]};
	assign mask_next    = {state_in.mask_value[23:0], state_in.number_value[7:0]};
	assign prefix_shift = 6'd32 - state_in.number_value[5:0];
	assign prefix_mask  = (state_in.number_value == 10'd0) ? 32'd0
		: (irlm_pkg::ALL_ONES << prefix_shift);

	always_comb begin
		state_out = state_in;
		if (state_in.found || state_in.error) begin
			state_out = state_in;
		end else if (state_in.phase == irlm_pkg::PH_GAP) begin
			if (is_digit) begin
				state_out.phase         = irlm_pkg::PH_ADDR;
				state_out.octet_index   = 2'd0;
				state_out.network_value = 32'd0;
				state_out.digit_count   = 2'd1;
				state_out.number_value  = digit_value;
			end
		end else if (is_digit && (state_in.digit_count < irlm_pkg::MAX_DIGITS)) begin
			state_out.number_value = acc_value;
			state_out.digit_count  = count_next;
			if ((count_next == irlm_pkg::MAX_DIGITS) && (acc_value > irlm_pkg::OCTET_MAX)) begin
				state_out.error = 1'b1;
			end
		end else if (state_in.digit_count == 2'd0) begin
			state_out.error = 1'b1;
		end else begin
			case (state_in.phase)
				irlm_pkg::PH_ADDR: begin
					state_out.network_value = network_next;
					if (state_in.octet_index < irlm_pkg::LAST_OCTET) begin
						if (char_code == irlm_pkg::CH_DOT) begin
							state_out.octet_index  = state_in.octet_index + 2'd1;
							state_out.digit_count  = 2'd0;
							state_out.number_value = 10'd0;
						end else begin
							state_out.error = 1'b1;
						end
					end else if (char_code == irlm_pkg::CH_SLASH) begin
						state_out.phase        = irlm_pkg::PH_PREFIX;
						state_out.digit_count  = 2'd0;
						state_out.number_value = 10'd0;
					end else begin
						state_out = finish_entry(state_out, irlm_pkg::ALL_ONES,
							test_address, is_digit);
					end
				end
				irlm_pkg::PH_PREFIX: begin
					if (char_code == irlm_pkg::CH_DOT) begin
						state_out.mask_value   = {22'd0, state_in.number_value};
						state_out.octet_index  = 2'd1;
						state_out.phase        = irlm_pkg::PH_MASK;
						state_out.digit_count  = 2'd0;
						state_out.number_value = 10'd0;
					end else if (state_in.number_value > irlm_pkg::PREFIX_MAX) begin
						state_out.error = 1'b1;
					end else begin
						state_out = finish_entry(state_out, prefix_mask, test_address, is_digit);
					end
				end
				default: begin
					state_out.mask_value = mask_next;
					if (state_in.octet_index < irlm_pkg::LAST_OCTET) begin
						if (char_code == irlm_pkg::CH_DOT) begin
							state_out.octet_index  = state_in.octet_index + 2'd1;
							state_out.digit_count  = 2'd0;
							state_out.number_value = 10'd0;
						end else begin
							state_out.error = 1'b1;
						end
					end else begin
						state_out = finish_entry(state_out, mask_next, test_address, is_digit);
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/irlm_core.sv */
// Parser state register with the per-character update and end-of-string close.
`timescale 1ns / 1ps
`default_nettype none
module irlm_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire irlm_pkg::in_word_t  word,
	input  wire logic [31:0]         test_address,
	output irlm_pkg::out_word_t      result
);

	irlm_pkg::parse_state_t state_q;
	irlm_pkg::parse_state_t after_char;
	irlm_pkg::parse_state_t after_end;

	irlm_step u_step_char (
		.state_in     (state_q),
		.char_code    (word.char_code),
		.test_address (test_address),
		.state_out    (after_char)
	);

	// close the string as if one more plain character arrived
	irlm_step u_step_end (
		.state_in     (after_char),
		.char_code    (irlm_pkg::CH_END),
		.test_address (test_address),
		.state_out    (after_end)
	);

	assign result.match_found  = after_end.found;
	assign result.syntax_error = after_end.error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irlm_pkg::PARSE_RESET;
		end else if (advance) begin
			state_q <= word.last_char ? irlm_pkg::PARSE_RESET : after_char;
		end
	end

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.found && state_q.error))
		else $error("found and error both set");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word.last_char |=> state_q == irlm_pkg::PARSE_RESET)
		else $error("parser not cleared after last character");

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the IPv4 range list matcher: allow-list strings in, verdicts out.
`timescale 1ns / 1ps
module tb_top;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 300;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	irlm_pkg::in_word_t     in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	irlm_pkg::out_word_t    out_data;
	logic                   cfg_we = 1'b0;
	logic [31:0]            cfg_data = '0;

	irlm_pkg::in_word_t     char_q[$];
	irlm_pkg::out_word_t    verdict_q[$];
	logic [7:0]             line_q[$];
	irlm_pkg::parse_state_t scan;
	logic [31:0]            test_addr;
	irlm_pkg::out_word_t    got_verdict;
	int                     mismatch_count = 0;
	int                     queued_total = 0;
	int                     quiet_cycles = 0;
	int                     send_gap = 0;
	int                     take_gap = 0;
	int                     hold_left = 0;
	logic                   hold_taken = 1'b0;
	logic                   hold_req = 1'b0;
	logic                   no_idle = 1'b0;

	ipv4_range_list_matcher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= irlm_pkg::CH_ZERO && c <= irlm_pkg::CH_NINE;
	endfunction

	task automatic note_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic close_entry(input logic [31:0] m, input logic [7:0] c);
		scan.mask_value = m;
		if ((test_addr & m) == (scan.network_value & m))
			scan.found = 1'b1;
		else if (is_numeral(c))
			scan.error = 1'b1;
		else
			scan.phase = irlm_pkg::PH_GAP;
	endtask

	task automatic scan_char(input logic [7:0] c);
		logic [9:0]  v;
		int unsigned pfx;
		if (scan.found || scan.error) begin
		end else if (scan.phase == irlm_pkg::PH_GAP) begin
			if (is_numeral(c)) begin
				scan.phase = irlm_pkg::PH_ADDR;
				scan.octet_index = 2'd0;
				scan.network_value = '0;
				scan.digit_count = 2'd1;
				scan.number_value = {2'b00, c - irlm_pkg::CH_ZERO};
			end
		end else if (is_numeral(c) && scan.digit_count < irlm_pkg::MAX_DIGITS) begin
			scan.number_value = 10'(scan.number_value * 10'd10
				+ {2'b00, c - irlm_pkg::CH_ZERO});
			scan.digit_count = scan.digit_count + 2'd1;
			if (scan.digit_count == irlm_pkg::MAX_DIGITS
				&& scan.number_value > irlm_pkg::OCTET_MAX)
				scan.error = 1'b1;
		end else if (scan.digit_count == 2'd0) begin
			scan.error = 1'b1;
		end else begin
			v = scan.number_value;
			case (scan.phase)
				irlm_pkg::PH_ADDR: begin
					scan.network_value = {scan.network_value[23:0], v[7:0]};
					if (scan.octet_index < irlm_pkg::LAST_OCTET) begin
						if (c == irlm_pkg::CH_DOT) begin
							scan.octet_index = scan.octet_index + 2'd1;
							scan.digit_count = 2'd0;
							scan.number_value = '0;
						end else begin
							scan.error = 1'b1;
						end
					end else if (c == irlm_pkg::CH_SLASH) begin
						scan.phase = irlm_pkg::PH_PREFIX;
						scan.digit_count = 2'd0;
						scan.number_value = '0;
					end else begin
						close_entry(irlm_pkg::ALL_ONES, c);
					end
				end
				irlm_pkg::PH_PREFIX: begin
					if (c == irlm_pkg::CH_DOT) begin
						scan.mask_value = {22'd0, v};
						scan.octet_index = 2'd1;
						scan.phase = irlm_pkg::PH_MASK;
						scan.digit_count = 2'd0;
						scan.number_value = '0;
					end else if (v > irlm_pkg::PREFIX_MAX) begin
						scan.error = 1'b1;
					end else begin
						pfx = {22'd0, v};
						close_entry((pfx == 0) ? 32'd0 : (irlm_pkg::ALL_ONES << (32 - pfx)), c);
					end
				end
				default: begin
					scan.mask_value = {scan.mask_value[23:0], v[7:0]};
					if (scan.octet_index < irlm_pkg::LAST_OCTET) begin
						if (c == irlm_pkg::CH_DOT) begin
							scan.octet_index = scan.octet_index + 2'd1;
							scan.digit_count = 2'd0;
							scan.number_value = '0;
						end else begin
							scan.error = 1'b1;
						end
					end else begin
						close_entry(scan.mask_value, c);
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_ready) begin
		end else if (send_gap != 0) begin
			send_gap <= send_gap - 1;
			in_valid <= 1'b0;
		end else if (char_q.size() == 0) begin
			in_valid <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 9) == 0) begin
			send_gap <= $urandom_range(0, 11);
			in_valid <= 1'b0;
		end else begin
			in_valid <= 1'b1;
			in_data <= char_q.pop_front();
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_gap <= 0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (take_gap != 0) begin
			take_gap <= take_gap - 1;
			out_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			take_gap <= $urandom_range(0, 11);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					note_mismatch("result word with none pending");
				end else begin
					got_verdict = verdict_q.pop_front();
					if (out_data.match_found !== got_verdict.match_found)
						note_mismatch($sformatf("match_found got %b want %b",
							out_data.match_found, got_verdict.match_found));
					if (out_data.syntax_error !== got_verdict.syntax_error)
						note_mismatch($sformatf("syntax_error got %b want %b",
							out_data.syntax_error, got_verdict.syntax_error));
				end
			end
			if (in_valid && in_ready) begin
				scan_char(in_data.char_code);
				if (in_data.last_char) begin
					scan_char(irlm_pkg::CH_END);
					verdict_q.push_back('{match_found: scan.found, syntax_error: scan.error});
					scan = irlm_pkg::PARSE_RESET;
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic drain();
		do
			@(negedge clk);
		while (char_q.size() != 0 || in_valid || verdict_q.size() != 0);
	endtask

	task automatic set_address(input logic [31:0] a);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= a;
		test_addr = a;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_q.size(); i++)
			char_q.push_back('{char_code: line_q[i], last_char: i == line_q.size() - 1});
		queued_total += line_q.size();
		line_q.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic add_quad(input logic [31:0] q);
		for (int i = 3; i >= 0; i--) begin
			if ($urandom_range(0, 7) == 0)
				add_text($sformatf("%03d", q[i*8 +: 8]));
			else
				add_text($sformatf("%0d", q[i*8 +: 8]));
			if (i != 0)
				line_q.push_back(irlm_pkg::CH_DOT);
		end
	endtask

	task automatic add_gap();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: add_text(",");
			1: add_text(", ");
			2: add_text(" ");
			3: add_text(";");
			default: begin
				do
					c = 8'($urandom_range(0, 255));
				while (is_numeral(c));
				line_q.push_back(c);
			end
		endcase
	endtask

	task automatic add_entry();
		logic [31:0] m;
		logic [31:0] base;
		logic [31:0] net;
		int          p;
		int          form;
		p = $urandom_range(0, 32);
		m = (p == 0) ? 32'd0 : (irlm_pkg::ALL_ONES << (32 - p));
		base = $urandom_range(0, 1) ? test_addr : $urandom;
		form = $urandom_range(0, 2);
		net = (form == 0) ? base : ((base & m) | ($urandom & ~m));
		if ($urandom_range(0, 3) == 0)
			net[$urandom_range(0, 31)] = ~net[$urandom_range(0, 31)];
		add_quad(net);
		if (form == 1) begin
			line_q.push_back(irlm_pkg::CH_SLASH);
			if ($urandom_range(0, 15) == 0)
				add_text($sformatf("%0d", $urandom_range(33, 99)));
			else
				add_text($sformatf("%0d", p));
		end else if (form == 2) begin
			line_q.push_back(irlm_pkg::CH_SLASH);
			add_quad($urandom_range(0, 3) == 0 ? $urandom : m);
		end
	endtask

	task automatic make_line();
		int kind;
		int n;
		int pos;
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			n = $urandom_range(1, 8);
			repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0)
				add_gap();
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				if (i != 0)
					add_gap();
				add_entry();
			end
			if ($urandom_range(0, 2) == 0)
				add_gap();
			if (kind < 6) begin
				pos = $urandom_range(0, line_q.size() - 1);
				case ($urandom_range(0, 2))
					0: line_q[pos] = 8'($urandom_range(0, 255));
					1: line_q.insert(pos, 8'(irlm_pkg::CH_ZERO + $urandom_range(0, 9)));
					default: if (line_q.size() > 1) line_q.delete(pos);
				endcase
			end
		end
		send_line();
	endtask

	task automatic fill_lines(input int n);
		int target;
		target = queued_total + n;
		while (queued_total < target)
			make_line();
	endtask

	initial begin
		scan = irlm_pkg::PARSE_RESET;
		test_addr = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_address(32'h0a000001);
		add_text("0.0.0.0/0");
		send_line();
		add_text("256");
		send_line();
		add_text("7.");
		send_line();
		line_q.push_back(8'hff);
		line_q.push_back(irlm_pkg::CH_END);
		send_line();
		add_text("10.0.0.1,1");
		send_line();

		set_address(32'h00000000);
		fill_lines(200);
		set_address(irlm_pkg::ALL_ONES);
		fill_lines(200);
		set_address($urandom);
		hold_req = 1'b1;
		fill_lines(250);
		set_address(32'hc0a80201);
		fill_lines(200);
		set_address($urandom);
		fill_lines(200);
		set_address($urandom);
		fill_lines(150);
		set_address($urandom);
		no_idle = 1'b1;
		fill_lines(200);

		drain();
		repeat (8) @(posedge clk);
		if (verdict_q.size() != 0)
			note_mismatch("verdicts still pending at end of run");
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
